// ----- hdl/bsc_pkg.sv -----
// shared types and decode constants for the branch successor predecoder
package bsc_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned PARCEL_W = 16;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned COUNT_W  = 2;

	localparam int unsigned S_DATA_W = 128;
	localparam int unsigned M_DATA_W = 104;
	localparam int unsigned M_USER_W = 3;

	localparam logic [PARCEL_W-1:0] PREFIX_PARCEL = 16'h2C00;

	// instruction lengths in bytes, before the prefix is counted
	localparam logic [LEN_W-1:0] LEN_ONE   = 4'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 4'd6;
	localparam logic [LEN_W-1:0] LEN_FIVE  = 4'd10;
	localparam logic [LEN_W-1:0] LEN_PREFIX = 4'd2;

	// one-parcel opcodes, bits 14..10
	localparam logic [4:0] OP_CALL    = 5'd1;
	localparam logic [4:0] OP_RET     = 5'd2;
	localparam logic [4:0] OP_JMP     = 5'd3;
	localparam logic [4:0] OP_COND_LO = 5'd4;
	localparam logic [4:0] OP_COND_HI = 5'd7;
	localparam logic [1:0] RET_TAG    = 2'b10;

	// three-parcel monadic form
	localparam logic [7:0] MONADIC_HI = 8'h80;
	localparam logic [3:0] SUB_CALL    = 4'd1;
	localparam logic [3:0] SUB_RET     = 4'd2;
	localparam logic [3:0] SUB_JMP     = 4'd3;
	localparam logic [3:0] SUB_COND_LO = 4'd4;
	localparam logic [3:0] SUB_COND_HI = 4'd7;

	localparam logic [3:0] MODE_IND2  = 4'hC;
	localparam logic [3:0] MODE_SPREL = 4'hD;
	localparam logic [3:0] MODE_PCREL = 4'hE;
	localparam logic [3:0] MODE_ABS   = 4'hF;

	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_DOUBLE = 2'd2
	} succ_kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   instr_address;
		logic [ADDR_W-1:0]   stack_pointer;
		logic [PARCEL_W-1:0] parcel0;
		logic [PARCEL_W-1:0] parcel1;
		logic [PARCEL_W-1:0] parcel2;
		logic [PARCEL_W-1:0] parcel3;
	} window_t;

	typedef struct packed {
		logic [LEN_W-1:0]   instr_length;
		logic               has_prefix;
		logic [COUNT_W-1:0] successor_count;
		succ_kind_t         successor_kind;
		logic [ADDR_W-1:0]  first_successor;
		logic [ADDR_W-1:0]  second_successor;
		logic [ADDR_W-1:0]  load_address;
	} succ_t;

endpackage

// ----- hdl/branch_successor_calc.sv -----
// top level: input register, successor decode and output register
//
//  channel | dir | tdata fields (low bit up)                     | tuser
//  s_*     | in  | instr_address, stack_pointer, parcel0..parcel3 | -
//  m_*     | out | instr_length, successor_count, first_successor,| has_prefix,
//          |     | second_successor, load_address, 2 pad bits     | successor_kind
//
// the window is registered in the input register, decoded and registered again in the
// output register; one window per cycle sustained while m_tready stays high; the decode
// adders between the two registers set the clock
// reset clears both stage valid bits, the payload registers are not reset
// a stalled result holds in the output register while the input register takes
// one more window; s_tready falls only when both are full and m_tready is low
module branch_successor_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// instr_address, stack_pointer, parcel0, parcel1, parcel2, parcel3
	input  logic [bsc_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// instr_length, successor_count, first_successor, second_successor,
	// load_address, zero pad
	output logic [bsc_pkg::M_DATA_W-1:0]  m_tdata,
	// has_prefix, successor_kind
	output logic [bsc_pkg::M_USER_W-1:0]  m_tuser
);
	import bsc_pkg::*;

	window_t win_s1;
	logic    vld_s1;
	succ_t   res_d;
	succ_t   res_s2;
	logic    vld_s2;
	logic    adv_s2;
	logic    adv_s1;

	assign adv_s2   = !vld_s2 || m_tready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			win_s1 <= window_t'({s_tdata[31:0], s_tdata[63:32], s_tdata[79:64],
				s_tdata[95:80], s_tdata[111:96], s_tdata[127:112]});
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_d;
		end
	end

	bsc_decode u_decode (
		.win (win_s1),
		.res (res_d)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {2'b00, res_s2.load_address, res_s2.second_successor,
		res_s2.first_successor, res_s2.successor_count, res_s2.instr_length};
	assign m_tuser  = {res_s2.successor_kind, res_s2.has_prefix};

	// an empty output register never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |-> s_tready)
		else $error("input stalled with empty output register");

	a_prefix_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (!res_s2.has_prefix || res_s2.instr_length >= 4'd4))
		else $error("prefixed instruction shorter than two parcels");

	a_indirect_no_first: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.successor_kind != KIND_DIRECT) |->
		(res_s2.first_successor == '0 && res_s2.successor_count == COUNT_W'(1)))
		else $error("indirect result carries a direct successor");

	a_pair_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.successor_count == COUNT_W'(2)) |->
		(res_s2.load_address == '0 && res_s2.successor_kind == KIND_DIRECT))
		else $error("conditional pair with load address");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !m_tready) |=> (vld_s2 && $stable(res_s2)))
		else $error("stalled result changed");

endmodule

// ----- hdl/bsc_decode.sv -----
// length and successor decode of one registered instruction window
module bsc_decode (
	input  bsc_pkg::window_t win,
	output bsc_pkg::succ_t   res
);
	import bsc_pkg::*;

	logic                pre;
	logic [PARCEL_W-1:0] p;
	logic [PARCEL_W-1:0] opa;
	logic [PARCEL_W-1:0] opb;
	logic [ADDR_W-1:0]   w;
	logic [ADDR_W-1:0]   base;
	logic [ADDR_W-1:0]   fall;
	logic [ADDR_W-1:0]   rel;
	logic [LEN_W-1:0]    len;
	logic [4:0]          op;
	logic [3:0]          sub;
	logic [3:0]          mode;

	assign pre  = (win.parcel0 == PREFIX_PARCEL);
	assign p    = pre ? win.parcel1 : win.parcel0;
	assign opa  = pre ? win.parcel2 : win.parcel1;
	assign opb  = pre ? win.parcel3 : win.parcel2;
	assign w    = {opa, opb};
	assign op   = p[14:10];
	assign sub  = p[3:0];
	assign mode = p[7:4];
	// branch offset counts parcels, signed 10 bits
	assign rel  = {{21{p[9]}}, p[9:0], 1'b0};

	always_comb begin
		if (!p[15]) begin
			len = LEN_ONE;
		end else if (!p[14]) begin
			len = LEN_THREE;
		end else begin
			len = LEN_FIVE;
		end
		if (pre) begin
			len = len + LEN_PREFIX;
		end
	end

	assign base = win.instr_address + {{(ADDR_W-2){1'b0}}, pre, 1'b0};
	assign fall = win.instr_address + {{(ADDR_W-LEN_W){1'b0}}, len};

	always_comb begin
		res                  = '0;
		res.instr_length     = len;
		res.has_prefix       = pre;
		res.successor_count  = COUNT_W'(1);
		res.successor_kind   = KIND_DIRECT;
		res.first_successor  = fall;
		if (!p[15]) begin
			unique case (op) inside
				OP_CALL, OP_JMP: begin
					res.first_successor = base + rel;
				end
				[OP_COND_LO:OP_COND_HI]: begin
					res.first_successor  = base + ADDR_W'(2);
					res.second_successor = base + rel;
					res.successor_count  = COUNT_W'(2);
				end
				OP_RET: begin
					if (p[1:0] == RET_TAG) begin
						res.successor_kind = KIND_LOAD;
						res.load_address   = win.stack_pointer +
							{{(ADDR_W-12){1'b0}}, p[9:2], 4'b0};
					end
				end
				default: begin
				end
			endcase
		end else if (p[15:8] == MONADIC_HI) begin
			unique case (sub) inside
				SUB_CALL, SUB_JMP: begin
					unique case (mode)
						MODE_IND2: begin
							res.successor_kind = KIND_DOUBLE;
							res.load_address   = w;
						end
						MODE_SPREL: begin
							res.successor_kind = KIND_LOAD;
							res.load_address   = win.stack_pointer + w;
						end
						MODE_PCREL: res.first_successor = base + w;
						MODE_ABS: begin
							res.successor_kind = KIND_LOAD;
							res.load_address   = w;
						end
						default: begin
						end
					endcase
				end
				[SUB_COND_LO:SUB_COND_HI]: begin
					unique case (mode)
						MODE_PCREL: res.first_successor = base + w;
						MODE_ABS: begin
							res.successor_kind = KIND_LOAD;
							res.load_address   = w;
						end
						default: begin
						end
					endcase
				end
				SUB_RET: begin
					res.successor_kind = KIND_LOAD;
					res.load_address   = win.stack_pointer + w;
				end
				default: begin
				end
			endcase
		end
		if (res.successor_kind != KIND_DIRECT) begin
			res.first_successor = '0;
		end
	end

endmodule
